[rtl/command_line_tokenizer_defines.svh]
// Assertion macros shared by the tokenizer RTL.
`ifndef COMMAND_LINE_TOKENIZER_DEFINES_SVH
`define COMMAND_LINE_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define CLT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tokenizer assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define CLT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tokenizer assertion failed");
`else
`define CLT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CLT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/clt_pkg.sv]
// Types, codes and constants of the command line tokenizer.
`default_nettype none

package clt_pkg;

  localparam int MAX_LINE_DEF = 512;
  localparam int MAX_ARGS_DEF = 255;

  localparam int START_W = 9;
  localparam int LEN_W   = 10;
  localparam int IDX_W   = 8;

  localparam logic [LEN_W-1:0] LEN_MAX = 10'd1023;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_LESS = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0D;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_ARG  = 2'd1;
  localparam logic [1:0] KIND_IN   = 2'd2;
  localparam logic [1:0] KIND_OUT  = 2'd3;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_NO_PROG    = 3'd1;
  localparam logic [2:0] ERR_NO_FILE    = 3'd2;
  localparam logic [2:0] ERR_AMP_POS    = 3'd3;
  localparam logic [2:0] ERR_BAD_REDIR  = 3'd4;
  localparam logic [2:0] ERR_TOO_LONG   = 3'd5;
  localparam logic [2:0] ERR_TOO_MANY   = 3'd6;

  typedef enum logic [9:0] {
    ST_START    = 10'b00_0000_0001,
    ST_GAP      = 10'b00_0000_0010,
    ST_ARG      = 10'b00_0000_0100,
    ST_WANT_IN  = 10'b00_0000_1000,
    ST_WANT_OUT = 10'b00_0001_0000,
    ST_IN       = 10'b00_0010_0000,
    ST_OUT      = 10'b00_0100_0000,
    ST_BG       = 10'b00_1000_0000,
    ST_DONE     = 10'b01_0000_0000,
    ST_ERR      = 10'b10_0000_0000
  } state_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last_of_line;
  } in_t;

  typedef struct packed {
    logic [1:0]         token_kind;
    logic [START_W-1:0] token_start;
    logic [LEN_W-1:0]   token_len;
    logic [IDX_W-1:0]   token_index;
    logic               background;
    logic [2:0]         error_code;
    logic               line_end;
  } out_t;

endpackage

`default_nettype wire

[rtl/command_line_tokenizer.sv]
// Command line tokenizer: one byte per beat in, one result beat out.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+-----------------------------
//   in       | to block  | in_valid_i/in_stall_o | clt_pkg::in_t  (byte, last)
//   out      | from block| out_valid_o/out_stall_i| clt_pkg::out_t (token, flags)
//
// Every accepted byte yields exactly one result beat, registered and shown in the next cycle.
// The next parser state is combinational, so a byte can be taken each clock unless the input stalls.
// A single output register holds the result; input stalls only while it is full
// and the downstream side stalls.
// Reset puts the parser in its start state and empties the output register.
`default_nettype none

module command_line_tokenizer #(
  parameter int MAX_LINE = clt_pkg::MAX_LINE_DEF,
  parameter int MAX_ARGS = clt_pkg::MAX_ARGS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire clt_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output clt_pkg::out_t      out_data_o
);

  import clt_pkg::*;

`include "command_line_tokenizer_defines.svh"

  localparam int POS_W  = $clog2(MAX_LINE + 1);
  localparam int BEG_W  = $clog2(MAX_LINE);
  localparam int ARGC_W = $clog2(MAX_ARGS + 1);

  localparam logic [POS_W-1:0]  POS_LIMIT  = POS_W'(MAX_LINE);
  localparam logic [ARGC_W-1:0] ARGS_LIMIT = ARGC_W'(MAX_ARGS);

  state_e              state_q, state_d;
  logic [2:0]          err_q, err_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [BEG_W-1:0]    begin_q, begin_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [ARGC_W-1:0]   argc_q, argc_d;
  logic                in_seen_q, in_seen_d;
  logic                out_seen_q, out_seen_d;
  logic                bg_q, bg_d;

  logic                out_valid_q, out_valid_d;
  out_t                out_data_q, out_data_d;

  logic                accept;
  logic                is_blank, is_op;
  logic                is_in, own_seen, other_seen;
  logic [7:0]          same_op;
  logic [7:0]          ch;

  assign ch         = in_data_i.ch;
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    is_blank = (ch inside {[CH_TAB:CH_CR], CH_SPACE});
    is_op    = (ch == CH_AMP) || (ch == CH_LESS) || (ch == CH_GT);
  end

  assign is_in      = (state_q == ST_IN);
  assign own_seen   = is_in ? in_seen_q : out_seen_q;
  assign other_seen = is_in ? out_seen_q : in_seen_q;
  assign same_op    = is_in ? CH_LESS : CH_GT;

  // Next parser state and the result for the byte on the input.
  always_comb begin
    state_d    = state_q;
    err_d      = err_q;
    pos_d      = pos_q;
    begin_d    = begin_q;
    len_d      = len_q;
    argc_d     = argc_q;
    in_seen_d  = in_seen_q;
    out_seen_d = out_seen_q;
    bg_d       = bg_q;
    out_data_d = '0;

    if (state_q != ST_DONE && state_q != ST_ERR) begin
      if (pos_q >= POS_LIMIT) begin
        state_d = ST_ERR;
        err_d   = ERR_TOO_LONG;
      end else if (ch == CH_NUL) begin
        state_d = ST_DONE;
      end else begin
        case (state_q)
          ST_START: begin
            if (is_op) begin
              state_d = ST_ERR;
              err_d   = ERR_NO_PROG;
            end else if (!is_blank) begin
              begin_d = BEG_W'(pos_q);
              len_d   = LEN_W'(1);
              state_d = ST_ARG;
            end
          end
          ST_ARG: begin
            if (!is_blank && !is_op) begin
              if (len_q != LEN_MAX) len_d = len_q + LEN_W'(1);
            end else if (argc_q >= ARGS_LIMIT) begin
              state_d = ST_ERR;
              err_d   = ERR_TOO_MANY;
            end else begin
              out_data_d.token_kind  = KIND_ARG;
              out_data_d.token_start = START_W'(begin_q);
              out_data_d.token_len   = len_q;
              out_data_d.token_index = IDX_W'(argc_q);
              argc_d = argc_q + ARGC_W'(1);
              len_d  = '0;
              if (is_blank) begin
                state_d = ST_GAP;
              end else if (ch == CH_AMP) begin
                bg_d    = 1'b1;
                state_d = ST_BG;
              end else if (ch == CH_LESS) begin
                state_d = ST_WANT_IN;
              end else begin
                state_d = ST_WANT_OUT;
              end
            end
          end
          ST_GAP: begin
            if (!is_blank) begin
              if (ch == CH_AMP) begin
                bg_d    = 1'b1;
                state_d = ST_BG;
              end else if (ch == CH_LESS) begin
                state_d = ST_WANT_IN;
              end else if (ch == CH_GT) begin
                state_d = ST_WANT_OUT;
              end else begin
                begin_d = BEG_W'(pos_q);
                len_d   = LEN_W'(1);
                state_d = ST_ARG;
              end
            end
          end
          ST_BG: begin
            if (!is_blank) begin
              state_d = ST_ERR;
              err_d   = ERR_AMP_POS;
            end
          end
          ST_WANT_IN, ST_WANT_OUT: begin
            if (is_op) begin
              state_d = ST_ERR;
              err_d   = ERR_NO_FILE;
            end else if (!is_blank) begin
              begin_d = BEG_W'(pos_q);
              len_d   = LEN_W'(1);
              state_d = (state_q == ST_WANT_IN) ? ST_IN : ST_OUT;
            end
          end
          ST_IN, ST_OUT: begin
            if (is_blank) begin
              if (len_q != '0) begin
                out_data_d.token_kind  = is_in ? KIND_IN : KIND_OUT;
                out_data_d.token_start = START_W'(begin_q);
                out_data_d.token_len   = len_q;
              end
              if (is_in) in_seen_d = 1'b1;
              else       out_seen_d = 1'b1;
              len_d = '0;
            end else if (ch == same_op) begin
              state_d = ST_ERR;
              err_d   = ERR_BAD_REDIR;
            end else if (ch == CH_AMP) begin
              if (!own_seen) begin
                state_d = ST_ERR;
                err_d   = ERR_BAD_REDIR;
              end else begin
                bg_d    = 1'b1;
                len_d   = '0;
                state_d = ST_BG;
              end
            end else if (is_op) begin
              if (!own_seen || other_seen) begin
                state_d = ST_ERR;
                err_d   = ERR_BAD_REDIR;
              end else begin
                len_d   = '0;
                state_d = is_in ? ST_WANT_OUT : ST_WANT_IN;
              end
            end else begin
              // A file word that follows whitespace starts a fresh token here.
              if (len_q == '0) begin_d = BEG_W'(pos_q);
              if (len_q != LEN_MAX) len_d = len_q + LEN_W'(1);
            end
          end
          default: begin
            state_d = state_q;
          end
        endcase
      end
    end

    if (pos_q < POS_LIMIT) pos_d = pos_q + POS_W'(1);

    out_data_d.background = bg_d;
    out_data_d.error_code = (state_d == ST_ERR) ? err_d : ERR_NONE;
    out_data_d.line_end   = in_data_i.last_of_line;
  end

  always_comb begin
    if (accept) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q & out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_START;
      err_q      <= ERR_NONE;
      pos_q      <= '0;
      begin_q    <= '0;
      len_q      <= '0;
      argc_q     <= '0;
      in_seen_q  <= 1'b0;
      out_seen_q <= 1'b0;
      bg_q       <= 1'b0;
    end else if (accept) begin
      if (in_data_i.last_of_line) begin
        state_q    <= ST_START;
        err_q      <= ERR_NONE;
        pos_q      <= '0;
        begin_q    <= '0;
        len_q      <= '0;
        argc_q     <= '0;
        in_seen_q  <= 1'b0;
        out_seen_q <= 1'b0;
        bg_q       <= 1'b0;
      end else begin
        state_q    <= state_d;
        err_q      <= err_d;
        pos_q      <= pos_d;
        begin_q    <= begin_d;
        len_q      <= len_d;
        argc_q     <= argc_d;
        in_seen_q  <= in_seen_d;
        out_seen_q <= out_seen_d;
        bg_q       <= bg_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `CLT_ASSERT_IMP(a_err_state_code, clk_i, rst_ni, 1'b1,
                  (state_q == ST_ERR) == (err_q != ERR_NONE))
  `CLT_ASSERT_IMP(a_no_token_fields, clk_i, rst_ni,
                  out_valid_q && (out_data_q.token_kind == KIND_NONE),
                  (out_data_q.token_start == '0) && (out_data_q.token_len == '0) &&
                  (out_data_q.token_index == '0))
  `CLT_ASSERT_NXT(a_line_restart, clk_i, rst_ni,
                  accept && in_data_i.last_of_line,
                  (state_q == ST_START) && (pos_q == '0) && (argc_q == '0) && !bg_q)
  `CLT_ASSERT_NXT(a_err_sticky, clk_i, rst_ni,
                  accept && !in_data_i.last_of_line && (state_q == ST_ERR),
                  (state_q == ST_ERR) && $stable(err_q))

endmodule

`default_nettype wire

[sim/clt_checker.sv]
// Checker for the command line tokenizer: predicts each result beat and compares.
`timescale 1ns / 100ps

module clt_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  clt_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  clt_pkg::out_t out_data_i,
  output int            fail_count_o,
  output int            pending_o,
  output int            tokens_o,
  output logic [7:0]    err_mask_o
);
  import clt_pkg::*;

  typedef enum logic [3:0] {
    P_START, P_GAP, P_ARG, P_WANT_IN, P_WANT_OUT, P_IN, P_OUT, P_BG, P_DONE, P_ERR
  } parse_e;

  parse_e     ps;
  logic [2:0] err;
  int         pos;
  int         tok_begin;
  int         tok_len;
  int         nargs;
  bit         in_seen;
  bit         out_seen;
  bit         bg;

  out_t report_q[$];
  int   bad_reports;
  int   tokens_seen;
  logic [7:0] err_seen;

  task automatic clear_line();
    ps = P_START;
    err = ERR_NONE;
    pos = 0;
    tok_begin = 0;
    tok_len = 0;
    nargs = 0;
    in_seen = 1'b0;
    out_seen = 1'b0;
    bg = 1'b0;
  endtask

  task automatic raise_error(input logic [2:0] code);
    ps = P_ERR;
    err = code;
  endtask

  task automatic open_word(input parse_e next);
    tok_begin = pos;
    tok_len = 1;
    ps = next;
  endtask

  task automatic grow_word();
    if (tok_len == 0) begin
      tok_begin = pos;
    end
    if (tok_len < int'(LEN_MAX)) begin
      tok_len++;
    end
  endtask

  // Advances the parser by one byte and builds the result beat it causes.
  task automatic tokenize_byte(input in_t b, output out_t r);
    logic [7:0] c;
    logic       blank;
    logic       oper;
    logic       to_in;
    logic       own;
    logic       other;
    logic [1:0] kind;
    int         start;
    int         len;
    int         idx;
    c = b.ch;
    blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    oper = (c == CH_AMP) || (c == CH_LESS) || (c == CH_GT);
    kind = KIND_NONE;
    start = 0;
    len = 0;
    idx = 0;
    if (ps != P_DONE && ps != P_ERR) begin
      if (pos >= MAX_LINE_DEF) begin
        raise_error(ERR_TOO_LONG);
      end else if (c == CH_NUL) begin
        ps = P_DONE;
      end else begin
        case (ps)
          P_START: begin
            if (oper) raise_error(ERR_NO_PROG);
            else if (!blank) open_word(P_ARG);
          end
          P_ARG: begin
            if (!blank && !oper) begin
              grow_word();
            end else if (nargs >= MAX_ARGS_DEF) begin
              raise_error(ERR_TOO_MANY);
            end else begin
              kind = KIND_ARG;
              start = tok_begin;
              len = tok_len;
              idx = nargs;
              nargs++;
              tok_len = 0;
              if (blank) ps = P_GAP;
              else if (c == CH_AMP) begin
                bg = 1'b1;
                ps = P_BG;
              end else if (c == CH_LESS) ps = P_WANT_IN;
              else ps = P_WANT_OUT;
            end
          end
          P_GAP: begin
            if (blank) begin
            end else if (c == CH_AMP) begin
              bg = 1'b1;
              ps = P_BG;
            end else if (c == CH_LESS) ps = P_WANT_IN;
            else if (c == CH_GT) ps = P_WANT_OUT;
            else open_word(P_ARG);
          end
          P_BG: begin
            if (!blank) raise_error(ERR_AMP_POS);
          end
          P_WANT_IN, P_WANT_OUT: begin
            if (oper) raise_error(ERR_NO_FILE);
            else if (!blank) open_word((ps == P_WANT_IN) ? P_IN : P_OUT);
          end
          P_IN, P_OUT: begin
            to_in = (ps == P_IN);
            own = to_in ? in_seen : out_seen;
            other = to_in ? out_seen : in_seen;
            if (blank) begin
              // A file name is only reported once whitespace closes it.
              if (tok_len > 0) begin
                kind = to_in ? KIND_IN : KIND_OUT;
                start = tok_begin;
                len = tok_len;
              end
              if (to_in) in_seen = 1'b1;
              else out_seen = 1'b1;
              tok_len = 0;
            end else if (c == (to_in ? CH_LESS : CH_GT)) begin
              raise_error(ERR_BAD_REDIR);
            end else if (c == CH_AMP) begin
              if (!own) raise_error(ERR_BAD_REDIR);
              else begin
                bg = 1'b1;
                tok_len = 0;
                ps = P_BG;
              end
            end else if (oper) begin
              if (!own || other) raise_error(ERR_BAD_REDIR);
              else begin
                tok_len = 0;
                ps = to_in ? P_WANT_OUT : P_WANT_IN;
              end
            end else begin
              grow_word();
            end
          end
          default: begin
          end
        endcase
      end
    end
    if (pos < MAX_LINE_DEF) begin
      pos++;
    end
    r.token_kind = kind;
    r.token_start = start[START_W-1:0];
    r.token_len = len[LEN_W-1:0];
    r.token_index = idx[IDX_W-1:0];
    r.background = bg;
    r.error_code = (ps == P_ERR) ? err : ERR_NONE;
    r.line_end = b.last_of_line;
    if (b.last_of_line) begin
      clear_line();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    out_t want;
    out_t got;
    if (!rst_ni) begin
      clear_line();
      report_q.delete();
      bad_reports = 0;
      tokens_seen = 0;
      err_seen = '0;
      fail_count_o <= 0;
      pending_o <= 0;
      tokens_o <= 0;
      err_mask_o <= '0;
    end else begin
      // Compare before predicting: a result can never belong to this edge's byte.
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (report_q.size() == 0) begin
          bad_reports++;
          if (bad_reports <= 10) begin
            $display("Result beat with nothing expected: %p", got);
          end
        end else begin
          want = report_q.pop_front();
          if (got !== want) begin
            bad_reports++;
            if (bad_reports <= 10) begin
              $display("Mismatch: expected kind %0d start %0d len %0d idx %0d bg %0d err %0d end %0d",
                       want.token_kind, want.token_start, want.token_len, want.token_index,
                       want.background, want.error_code, want.line_end);
              $display("          actual   kind %0d start %0d len %0d idx %0d bg %0d err %0d end %0d",
                       got.token_kind, got.token_start, got.token_len, got.token_index,
                       got.background, got.error_code, got.line_end);
            end
          end
          if (want.token_kind != KIND_NONE) tokens_seen++;
          if (want.line_end) err_seen[want.error_code] = 1'b1;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        tokenize_byte(in_data_i, want);
        report_q.push_back(want);
      end
      fail_count_o <= bad_reports;
      pending_o <= report_q.size();
      tokens_o <= tokens_seen;
      err_mask_o <= err_seen;
    end
  end

endmodule

[sim/tb_command_line_tokenizer.sv]
// Testbench top for the command line tokenizer: byte stimulus, idling and verdict.
`timescale 1ns / 100ps

module tb_command_line_tokenizer;
  import clt_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int PHASE_BYTES = 50;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  int         fail_count;
  int         pending;
  int         tokens;
  logic [7:0] err_mask;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int bytes_sent = 0;
  int lines_sent = 0;
  int quiet_cycles = 0;
  int phase_start = 0;

  logic [7:0] line_q[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  command_line_tokenizer #(
    .MAX_LINE(MAX_LINE_DEF),
    .MAX_ARGS(MAX_ARGS_DEF)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  clt_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .tokens_o    (tokens),
    .err_mask_o  (err_mask)
  );

  always @(posedge clk) begin
    if (rst_n) out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no beat accepted for %0d cycles", quiet_cycles);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Any nonzero byte that is neither whitespace nor an operator.
  function automatic logic [7:0] word_byte();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    while (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR) ||
           c == CH_AMP || c == CH_LESS || c == CH_GT) begin
      c = 8'($urandom_range(1, 255));
    end
    return c;
  endfunction

  function automatic logic [7:0] blank_byte();
    int unsigned r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
  endfunction

  task automatic add_word();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
    repeat (n) line_q.push_back(word_byte());
  endtask

  task automatic add_blanks(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) line_q.push_back(blank_byte());
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic send_beat(input in_t beat);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Sends the collected line, marking its final byte, and empties the buffer.
  task automatic send_line();
    in_t beat;
    for (int i = 0; i < line_q.size(); i++) begin
      beat.ch = line_q[i];
      beat.last_of_line = (i == line_q.size() - 1);
      send_beat(beat);
    end
    lines_sent++;
    line_q.delete();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic add_redirect(input logic [7:0] op);
    if ($urandom_range(0, 2) != 0) add_blanks(1, 1);
    line_q.push_back(op);
    if ($urandom_range(0, 1) != 0) add_blanks(1, 2);
    add_word();
    // Occasionally a second word, which becomes a new file name of the same kind.
    if ($urandom_range(0, 7) == 0) begin
      add_blanks(1, 1);
      add_word();
    end
    if ($urandom_range(0, 9) != 0) add_blanks(1, 1);
  endtask

  task automatic build_random_line();
    int unsigned flavor;
    int unsigned at;
    logic [7:0] v;
    flavor = $urandom_range(0, 99);
    if (flavor < 10) begin
      repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 3) == 0) add_blanks(1, 2);
    add_word();
    repeat ($urandom_range(0, 3)) begin
      add_blanks(1, 2);
      add_word();
    end
    if ($urandom_range(0, 1) != 0) begin
      if ($urandom_range(0, 1) != 0) add_redirect(CH_LESS);
      if ($urandom_range(0, 1) != 0) add_redirect(CH_GT);
    end else begin
      if ($urandom_range(0, 1) != 0) add_redirect(CH_GT);
      if ($urandom_range(0, 1) != 0) add_redirect(CH_LESS);
    end
    if ($urandom_range(0, 3) == 0) begin
      add_blanks(0, 1);
      line_q.push_back(CH_AMP);
    end
    if ($urandom_range(0, 3) == 0) add_blanks(1, 2);
    if (flavor < 35) begin
      at = $urandom_range(0, line_q.size() - 1);
      case ($urandom_range(0, 4))
        0: v = CH_AMP;
        1: v = CH_LESS;
        2: v = CH_GT;
        3: v = CH_NUL;
        default: v = 8'($urandom_range(0, 255));
      endcase
      if ($urandom_range(0, 1) != 0) line_q.insert(at, v);
      else line_q[at] = v;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines: a full command, each syntax error, high and zero bytes,
    // and a whitespace only line.
    add_text("ls <i >o &");
    send_line();
    line_q.push_back(CH_AMP);
    send_line();
    add_text("a<<");
    send_line();
    add_text("a&b");
    send_line();
    add_text("a<f>");
    send_line();
    line_q.push_back(8'hFF);
    line_q.push_back(CH_NUL);
    send_line();
    line_q.push_back(CH_SPACE);
    line_q.push_back(CH_TAB);
    send_line();
    drain();

    // Two full length lines: one runs out of argument slots, one runs past the end.
    repeat (MAX_ARGS_DEF + 1) begin
      line_q.push_back(word_byte());
      line_q.push_back(blank_byte());
    end
    send_line();
    repeat (MAX_LINE_DEF - 1) line_q.push_back(word_byte());
    line_q.push_back(blank_byte());
    line_q.push_back(word_byte());
    line_q.push_back(word_byte());
    send_line();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 57; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 57; end
        default: begin send_idle_pct = 21; stall_pct = 21; end
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        build_random_line();
        send_line();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d bytes in %0d lines under four idling mixes; %0d tokens reported,",
             bytes_sent, lines_sent, tokens);
    $display("error codes seen at line end (bit per code): %b", err_mask);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
